[hdl/scm_pkg.sv]
// ----------------------------------------------------------------------------
// Sign change contour marker package
// Shared constants, types and the sample sign test.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int MAX_ROW_SAMPLES = 1024;
  localparam int COL_W           = $clog2(MAX_ROW_SAMPLES);
  localparam int ROW_W           = 16;
  localparam int GW_W            = 11;
  localparam int SAMPLE_W        = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST   = GW_W'(81);
  localparam logic [ROW_W-1:0] GRID_HEIGHT_RST  = ROW_W'(25);
  localparam logic             OUTLINE_MODE_RST = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GRID_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_GRID_HEIGHT  = 2'd1;
  localparam cfg_idx_t CFG_OUTLINE_MODE = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pos_t;

  // Positive means sign clear, not zero and not NaN; infinity counts.
  function automatic logic is_positive(input logic [SAMPLE_W-1:0] bits);
    logic [SAMPLE_W-2:0] mag;
    mag = bits[SAMPLE_W-2:0];
    return !bits[SAMPLE_W-1] && (mag != '0) && (mag <= 31'h7F80_0000);
  endfunction

endpackage

[hdl/scm_if.sv]
// ----------------------------------------------------------------------------
// Sign change contour marker channels
// Valid/ready channels for input samples and result marks.
// ----------------------------------------------------------------------------
interface scm_in_if import scm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_bits;

  modport source (output valid, output sample_bits, input ready);
  modport sink (input valid, input sample_bits, output ready);
endinterface

interface scm_out_if import scm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             mark;
  logic [COL_W-1:0] cell_column;
  logic [ROW_W-1:0] cell_row;
  logic             frame_last;

  modport source (output valid, output mark, output cell_column, output cell_row,
                  output frame_last, input ready);
  modport sink (input valid, input mark, input cell_column, input cell_row,
                input frame_last, output ready);
endinterface

[hdl/sign_change_contour_marker_top.sv]
// ----------------------------------------------------------------------------
// Sign change contour marker
// Marks positive samples, or 2x2 cells holding both signs, of a raster grid.
// ----------------------------------------------------------------------------
// Samples enter on in_ch in raster order, one binary32 pattern per item, and
// marks leave on out_ch with their cell column, cell row and a flag on the
// last mark of a frame. Both channels move an item when valid and ready are
// high at a rising edge. The block takes one item per clock while out_ch is
// not stalled. A mark is formed in the first stage, the sample register and
// the registered read of the one-row sign buffer, and leaves from the result
// register, the second stage. In outline mode the first row and first column
// of each frame give no mark. The cfg port sets grid width, grid height and
// mode, and a write to any of these restarts the frame at column and row zero;
// the user must write it only while the block is idle, which the block does
// not enforce. Synchronous reset clears both valid flags, the position
// counters and the left signs, and loads width 81, height 25 and outline mode.
// When the receiver holds ready low the mark waits, one more item that gives a
// mark enters the middle stage, then in_ch.ready falls until out_ch drains.
// ----------------------------------------------------------------------------
module sign_change_contour_marker_top import scm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  scm_in_if.sink                in_ch,
  scm_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [GW_W-1:0]  grid_width_r;
  logic [ROW_W-1:0] grid_height_r;
  logic             outline_mode_r;
  logic             cfg_hit;
  logic [COL_W-1:0] width_m1;
  logic [ROW_W-1:0] height_m1;

  logic             accept;
  logic             cur_sign;
  logic             above_sign;
  pos_t             pos;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_cur_r;
  pos_t             s1_pos_r;
  logic             s1_emit;
  logic             s1_adv;
  logic             left_cur_r;
  logic             left_above_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_mark_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_last_r;

  always_comb begin
    case (cfg_index)
      CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_OUTLINE_MODE: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= GRID_WIDTH_RST;
      grid_height_r  <= GRID_HEIGHT_RST;
      outline_mode_r <= OUTLINE_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:   grid_width_r   <= cfg_wdata[GW_W-1:0];
        CFG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata[ROW_W-1:0];
        CFG_OUTLINE_MODE: outline_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width_r < GW_W'(2)) begin
      width_m1 = COL_W'(1);
    end else if (int'(grid_width_r) > MAX_ROW_SAMPLES) begin
      width_m1 = COL_W'(MAX_ROW_SAMPLES - 1);
    end else begin
      width_m1 = COL_W'(grid_width_r - GW_W'(1));
    end
    height_m1 = (grid_height_r < ROW_W'(2)) ? ROW_W'(1) : grid_height_r - ROW_W'(1);
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign cur_sign = is_positive(in_ch.sample_bits);

  scm_raster_ctr u_ctr (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .restart   (cfg_hit),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .pos       (pos)
  );

  scm_line_buf u_line_buf (
    .clk     (clk),
    .en      (accept),
    .addr    (pos.col),
    .wr_data (cur_sign),
    .rd_data (above_sign)
  );

  assign s1_emit  = !outline_mode_r || ((s1_pos_r.col != '0) && (s1_pos_r.row != '0));
  assign s1_adv   = s1_valid_r && (!s1_emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      left_cur_r   <= 1'b0;
      left_above_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        left_cur_r   <= s1_cur_r;
        left_above_r <= above_sign;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r <= cur_sign;
      s1_pos_r <= pos;
    end
    if (s1_adv && s1_emit) begin
      out_last_r <= s1_pos_r.last;
      if (outline_mode_r) begin
        out_mark_r <= !((left_above_r == above_sign) && (above_sign == left_cur_r) &&
                        (left_cur_r == s1_cur_r));
        out_col_r  <= s1_pos_r.col - COL_W'(1);
        out_row_r  <= s1_pos_r.row - ROW_W'(1);
      end else begin
        out_mark_r <= s1_cur_r;
        out_col_r  <= s1_pos_r.col;
        out_row_r  <= s1_pos_r.row;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mark        = out_mark_r;
  assign out_ch.cell_column = out_col_r;
  assign out_ch.cell_row    = out_row_r;
  assign out_ch.frame_last  = out_last_r;

endmodule

[hdl/scm_line_buf.sv]
// ----------------------------------------------------------------------------
// Sign line buffer
// One row of sample signs; reads the old entry while writing the new one.
// ----------------------------------------------------------------------------
module scm_line_buf import scm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [COL_W-1:0] addr,
  input  logic             wr_data,
  output logic             rd_data
);

  logic mem [MAX_ROW_SAMPLES];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r  <= mem[addr];
      mem[addr]  <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/scm_raster_ctr.sv]
// ----------------------------------------------------------------------------
// Raster position counter
// Tracks column and row of the next sample and flags the frame's last one.
// ----------------------------------------------------------------------------
module scm_raster_ctr import scm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             restart,
  input  logic [COL_W-1:0] width_m1,
  input  logic [ROW_W-1:0] height_m1,
  output pos_t             pos
);

  logic [COL_W-1:0] col_r, col_nxt, col_c;
  logic [ROW_W-1:0] row_r, row_nxt, row_c;
  logic             row_end;

  always_comb begin
    col_c    = (col_r > width_m1) ? width_m1 : col_r;
    row_c    = (row_r > height_m1) ? height_m1 : row_r;
    row_end  = (col_c == width_m1);
    pos.col  = col_c;
    pos.row  = row_c;
    pos.last = row_end && (row_c == height_m1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_c == height_m1) ? '0 : row_c + ROW_W'(1);
      end else begin
        col_nxt = col_c + COL_W'(1);
        row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[hdl/scm_checker.sv]
// ----------------------------------------------------------------------------
// Sign change contour marker checker
// Port-level properties of the marker, bound to its top level.
// ----------------------------------------------------------------------------
module scm_checker import scm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             mark,
  input logic [COL_W-1:0] cell_column,
  input logic [ROW_W-1:0] cell_row,
  input logic             frame_last
);

  // A waiting mark keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mark) && $stable(cell_column) &&
    $stable(cell_row) && $stable(frame_last))
    else $error("result item changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the block must take a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind sign_change_contour_marker_top scm_checker u_scm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .mark        (out_ch.mark),
  .cell_column (out_ch.cell_column),
  .cell_row    (out_ch.cell_row),
  .frame_last  (out_ch.frame_last)
);
